>>> design/svre_pkg.sv
// shared types and constants for the separated-values row encoder
`default_nettype none

package svre_pkg;

   localparam int FILL_W = 5;

   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_FIELD = 2'd1;
   localparam logic [1:0] OP_ROW   = 2'd2;

   localparam logic [1:0] REG_SEPARATOR = 2'd0;
   localparam logic [1:0] REG_QUOTE     = 2'd1;
   localparam logic [1:0] REG_ESCAPE    = 2'd2;
   localparam logic [1:0] REG_DQ_MODE   = 2'd3;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   localparam logic [7:0] RESET_SEPARATOR = 8'd44;
   localparam logic [7:0] RESET_QUOTE     = 8'd34;
   localparam logic [7:0] RESET_ESCAPE    = 8'd92;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_byte;
   } svre_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       truncated;
   } svre_rsp_type;

   typedef struct packed {
      logic [7:0] separator_char;
      logic [7:0] quote_byte;
      logic [7:0] escape_byte;
      logic       double_quote_mode;
   } svre_cfg_type;

   typedef struct packed {
      logic              row;
      logic              emit;
      logic              first;
      logic              quoting;
      logic              overflow;
      logic [FILL_W-1:0] fill;
   } svre_cmd_type;

   typedef struct packed {
      logic              en;
      logic [FILL_W-1:0] addr;
      logic [7:0]        data;
   } svre_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEP,
      ST_OPEN,
      ST_BODY,
      ST_CLOSE,
      ST_LF
   } svre_state_type;

endpackage

`default_nettype wire

>>> design/svre_front.sv
// front end: takes beats, fills the field buffer, queues end-of-field and end-of-row commands
`default_nettype none

module svre_front #(
   parameter int FIELD_MAX = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  svre_pkg::svre_req_type req_data,
   input  svre_pkg::svre_cfg_type cfg,
   input  wire                   back_busy,
   input  wire                   q_full,
   input  wire                   q_empty,
   output logic                  push,
   output svre_pkg::svre_cmd_type cmd,
   output svre_pkg::svre_wr_type  wr
);
   import svre_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              quoting_ff, quoting_in;
   logic              overflow_ff, overflow_in;
   logic              first_ff, first_in;
   logic              is_char, accept, has_room, special;

   always_comb begin
      is_char   = (req_data.opcode == OP_CHAR);
      req_stall = q_full || (is_char && (!q_empty || back_busy));
      accept    = req_valid && !req_stall;
      has_room  = (fill_ff < FILL_W'(FIELD_MAX));
      special   = (req_data.char_byte == cfg.separator_char) ||
                  (req_data.char_byte == cfg.quote_byte) ||
                  (req_data.char_byte == cfg.escape_byte) ||
                  (req_data.char_byte == CH_CR) ||
                  (req_data.char_byte == CH_LF);

      wr.en   = accept && is_char && has_room;
      wr.addr = fill_ff;
      wr.data = req_data.char_byte;

      push         = accept && ((req_data.opcode == OP_FIELD) || (req_data.opcode == OP_ROW));
      cmd.row      = (req_data.opcode == OP_ROW);
      cmd.emit     = (req_data.opcode == OP_FIELD) || (fill_ff != '0) || overflow_ff;
      cmd.first    = first_ff;
      cmd.quoting  = quoting_ff;
      cmd.overflow = overflow_ff;
      cmd.fill     = fill_ff;

      fill_in     = fill_ff;
      quoting_in  = quoting_ff;
      overflow_in = overflow_ff;
      first_in    = first_ff;
      if (accept) begin
         case (req_data.opcode)
            OP_CHAR: begin
               if (has_room) begin
                  fill_in    = fill_ff + FILL_W'(1);
                  quoting_in = quoting_ff || special;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            OP_FIELD: begin
               fill_in     = '0;
               quoting_in  = 1'b0;
               overflow_in = 1'b0;
               first_in    = 1'b0;
            end
            OP_ROW: begin
               fill_in     = '0;
               quoting_in  = 1'b0;
               overflow_in = 1'b0;
               first_in    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         quoting_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         first_ff    <= 1'b1;
      end else begin
         fill_ff     <= fill_in;
         quoting_ff  <= quoting_in;
         overflow_ff <= overflow_in;
         first_ff    <= first_in;
      end
   end

endmodule

`default_nettype wire

>>> design/svre_cmd_fifo.sv
// two-entry command queue between front and back
`default_nettype none

module svre_cmd_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  svre_pkg::svre_cmd_type push_data,
   input  wire                   pop,
   output svre_pkg::svre_cmd_type pop_data,
   output logic                  full,
   output logic                  empty
);
   import svre_pkg::*;

   svre_cmd_type entry_ff [2];
   logic         wptr_ff, rptr_ff;
   logic [1:0]   count_ff;

   always_comb begin
      full     = (count_ff == 2'd2);
      empty    = (count_ff == 2'd0);
      pop_data = entry_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

>>> design/svre_back.sv
// back end: field buffer and byte emitter with the output register
`default_nettype none

module svre_back #(
   parameter int FIELD_MAX = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  svre_pkg::svre_cfg_type cfg,
   input  svre_pkg::svre_wr_type  wr,
   input  wire                   q_empty,
   input  svre_pkg::svre_cmd_type q_data,
   output logic                  q_pop,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output svre_pkg::svre_rsp_type rsp_data
);
   import svre_pkg::*;

   localparam int IDX_W = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;

   logic [7:0]     buf_mem [FIELD_MAX];
   logic [7:0]     cur_ff;
   svre_state_type state_ff, state_in;
   svre_cmd_type   cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic           pre_ff, pre_in;
   logic           rsp_valid_ff, rsp_valid_in;
   svre_rsp_type   rsp_data_ff, rsp_data_in;
   logic [7:0]     cur_char, pre_byte, out_byte;
   logic           need_pre, last_char, out_free, emit, trunc;

   function automatic svre_state_type after_field(input svre_cmd_type c);
      return c.row ? ST_LF : ST_IDLE;
   endfunction

   function automatic svre_state_type after_sep(input svre_cmd_type c);
      svre_state_type s;
      if (c.emit && c.quoting) begin
         s = ST_OPEN;
      end else if (c.emit && (c.fill != '0)) begin
         s = ST_BODY;
      end else begin
         s = after_field(c);
      end
      return s;
   endfunction

   function automatic svre_state_type start_state(input svre_cmd_type c);
      return (c.emit && !c.first) ? ST_SEP : after_sep(c);
   endfunction

   // read data follows the next index, so it lines up with idx_ff
   always_ff @(posedge clock) begin
      if (wr.en) begin
         buf_mem[wr.addr[IDX_W-1:0]] <= wr.data;
      end
      cur_ff <= buf_mem[idx_in];
   end

   always_comb begin
      cur_char  = cur_ff;
      need_pre  = cmd_ff.quoting && ((cur_char == cfg.separator_char) ||
                  (cur_char == cfg.quote_byte) || (cur_char == cfg.escape_byte));
      pre_byte  = ((cur_char == cfg.quote_byte) && cfg.double_quote_mode) ?
                  cfg.quote_byte : cfg.escape_byte;
      last_char = (FILL_W'(idx_ff) == (cmd_ff.fill - FILL_W'(1)));
      out_free  = !rsp_valid_ff || !rsp_stall;

      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      pre_in   = pre_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      out_byte = cfg.separator_char;
      trunc    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               idx_in   = '0;
               pre_in   = 1'b0;
               state_in = start_state(q_data);
            end
         end
         ST_SEP: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = after_sep(cmd_ff);
            end
         end
         ST_OPEN: begin
            out_byte = cfg.quote_byte;
            trunc    = cmd_ff.overflow;
            if (out_free) begin
               emit     = 1'b1;
               state_in = (cmd_ff.fill != '0) ? ST_BODY : ST_CLOSE;
            end
         end
         ST_BODY: begin
            trunc = cmd_ff.overflow;
            if (need_pre && !pre_ff) begin
               out_byte = pre_byte;
            end else begin
               out_byte = cur_char;
            end
            if (out_free) begin
               emit = 1'b1;
               if (need_pre && !pre_ff) begin
                  pre_in = 1'b1;
               end else begin
                  pre_in = 1'b0;
                  idx_in = idx_ff + IDX_W'(1);
                  if (last_char) begin
                     state_in = cmd_ff.quoting ? ST_CLOSE : after_field(cmd_ff);
                  end
               end
            end
         end
         ST_CLOSE: begin
            out_byte = cfg.quote_byte;
            trunc    = cmd_ff.overflow;
            if (out_free) begin
               emit     = 1'b1;
               state_in = after_field(cmd_ff);
            end
         end
         ST_LF: begin
            out_byte = CH_LF;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      if (emit) begin
         rsp_data_in.out_byte     = out_byte;
         rsp_data_in.last_of_item = (state_in == ST_IDLE);
         rsp_data_in.truncated    = trunc;
      end else begin
         rsp_data_in = rsp_data_ff;
      end

      busy      = (state_ff != ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      pre_ff      <= pre_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/separated_values_row_encoder_core.sv
// top level of the separated-values row encoder: config registers, front, queue, back
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | svre_req_type  (opcode, char_byte)
//  rsp     | out       | rsp_valid/rsp_stall | svre_rsp_type  (out_byte, last_of_item, truncated)
//  csr     | in        | csr_psel/csr_penable | 32-bit registers at 4*i
//
//  a field character waits while the back end still drains a field
//  an end mark is registered in the queue and then taken by the back end, which then
//  sends one byte a cycle while the output is not stalled, at most 2*n+4 bytes for a
//  field of n characters, so its pace follows the output port
//  reset is synchronous and clears control state only; no clearing pass is run
//  a stalled output holds its byte while the front keeps queueing up to two end marks
`default_nettype none

module separated_values_row_encoder_core #(
   parameter int FIELD_MAX = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  svre_pkg::svre_req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output svre_pkg::svre_rsp_type rsp_data,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [3:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import svre_pkg::*;

   svre_cfg_type cfg_ff, cfg_in;
   svre_cmd_type push_cmd, pop_cmd;
   svre_wr_type  wr;
   logic         csr_write, push, pop, q_full, q_empty, back_busy;

   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_SEPARATOR: cfg_in.separator_char    = csr_pwdata[7:0];
            REG_QUOTE:     cfg_in.quote_byte        = csr_pwdata[7:0];
            REG_ESCAPE:    cfg_in.escape_byte       = csr_pwdata[7:0];
            REG_DQ_MODE:   cfg_in.double_quote_mode = csr_pwdata[0];
            default: begin
            end
         endcase
      end
      case (csr_paddr[3:2])
         REG_SEPARATOR: csr_prdata = {24'd0, cfg_ff.separator_char};
         REG_QUOTE:     csr_prdata = {24'd0, cfg_ff.quote_byte};
         REG_ESCAPE:    csr_prdata = {24'd0, cfg_ff.escape_byte};
         REG_DQ_MODE:   csr_prdata = {31'd0, cfg_ff.double_quote_mode};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_char    <= RESET_SEPARATOR;
         cfg_ff.quote_byte        <= RESET_QUOTE;
         cfg_ff.escape_byte       <= RESET_ESCAPE;
         cfg_ff.double_quote_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   svre_front #(.FIELD_MAX(FIELD_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .back_busy (back_busy),
      .q_full    (q_full),
      .q_empty   (q_empty),
      .push      (push),
      .cmd       (push_cmd),
      .wr        (wr)
   );

   svre_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   svre_back #(.FIELD_MAX(FIELD_MAX)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .wr        (wr),
      .q_empty   (q_empty),
      .q_data    (pop_cmd),
      .q_pop     (pop),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/svre_checker.sv
// port-level checks for the row encoder and their bind
`default_nettype none

module svre_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input svre_pkg::svre_req_type req_data,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input svre_pkg::svre_rsp_type rsp_data,
   input wire                   csr_pready
);
   import svre_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_char_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == OP_CHAR)
      |=> !rsp_valid || $past(rsp_valid && rsp_stall))
      else $error("field character produced a result beat");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr port not ready");

endmodule

bind separated_values_row_encoder_core svre_checker u_svre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the separated-values row encoder core
module testbench;
   import svre_pkg::*;

   localparam int FIELD_MAX = 16;
   localparam int IDLE_PCT = 12;
   localparam int SETTLE = 40;
   localparam int LIMIT = 800000;
   localparam logic [1:0] OP_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   svre_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   svre_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   svre_cfg_type cfg_now = '{separator_char: RESET_SEPARATOR, quote_byte: RESET_QUOTE,
                             escape_byte: RESET_ESCAPE, double_quote_mode: 1'b1};
   logic [7:0] fld_buf [FIELD_MAX];
   int fld_fill = 0;
   logic fld_quote = 1'b0;
   logic fld_over = 1'b0;
   logic row_first = 1'b1;
   svre_rsp_type beat_bytes[$];
   svre_rsp_type expected_bytes[$];
   int errors = 0;
   int sent = 0;
   int hold_left = 0;
   int cycles = 0;
   logic quiet = 1'b0;

   separated_values_row_encoder_core #(.FIELD_MAX(FIELD_MAX)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[separated_values_row_encoder_core] ERROR");
         $finish;
      end
   end

   // receiver side: random stall, long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic void put_out(input logic [7:0] b, input logic t);
      beat_bytes.push_back('{out_byte: b, last_of_item: 1'b0, truncated: t});
   endfunction

   function automatic void write_field();
      logic t;
      logic [7:0] c;
      t = fld_over;
      if (!row_first) put_out(cfg_now.separator_char, 1'b0);
      row_first = 1'b0;
      if (fld_quote) begin
         put_out(cfg_now.quote_byte, t);
         for (int i = 0; i < fld_fill; i++) begin
            c = fld_buf[i];
            if (c == cfg_now.separator_char || c == cfg_now.quote_byte) begin
               if (c == cfg_now.quote_byte && cfg_now.double_quote_mode) put_out(c, t);
               else put_out(cfg_now.escape_byte, t);
            end else if (c == cfg_now.escape_byte) begin
               put_out(cfg_now.escape_byte, t);
            end
            put_out(c, t);
         end
         put_out(cfg_now.quote_byte, t);
      end else begin
         for (int i = 0; i < fld_fill; i++) put_out(fld_buf[i], t);
      end
      fld_fill = 0;
      fld_quote = 1'b0;
      fld_over = 1'b0;
   endfunction

   function automatic void encode_beat(input svre_req_type r);
      svre_rsp_type b;
      beat_bytes.delete();
      case (r.opcode)
         OP_CHAR: begin
            if (fld_fill < FIELD_MAX) begin
               fld_buf[fld_fill] = r.char_byte;
               fld_fill++;
               if (r.char_byte == cfg_now.separator_char || r.char_byte == cfg_now.quote_byte ||
                   r.char_byte == cfg_now.escape_byte || r.char_byte == CH_CR ||
                   r.char_byte == CH_LF)
                  fld_quote = 1'b1;
            end else begin
               fld_over = 1'b1;
            end
         end
         OP_FIELD: write_field();
         OP_ROW: begin
            if (fld_fill != 0 || fld_over) write_field();
            put_out(CH_LF, 1'b0);
            row_first = 1'b1;
         end
         default: ;
      endcase
      foreach (beat_bytes[i]) begin
         b = beat_bytes[i];
         b.last_of_item = (i == beat_bytes.size() - 1);
         expected_bytes.push_back(b);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
   endtask

   task automatic check_beat(input svre_rsp_type got);
      svre_rsp_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected beat, byte %02h", got.out_byte));
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
         report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last_of_item !== want.last_of_item)
         report_mismatch($sformatf("last_of_item %b, want %b on byte %02h",
                                   got.last_of_item, want.last_of_item, want.out_byte));
      if (got.truncated !== want.truncated)
         report_mismatch($sformatf("truncated %b, want %b on byte %02h",
                                   got.truncated, want.truncated, want.out_byte));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) encode_beat(req_data);
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
      end
   end

   task automatic send_beat(input logic [1:0] op, input logic [7:0] ch);
      int gap;
      gap = 0;
      if (!quiet) while ($urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{opcode: op, char_byte: ch};
      do @(posedge clock); while (req_stall);
      if (op != OP_NONE) sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SEPARATOR: cfg_now.separator_char = val[7:0];
         REG_QUOTE:     cfg_now.quote_byte = val[7:0];
         REG_ESCAPE:    cfg_now.escape_byte = val[7:0];
         REG_DQ_MODE:   cfg_now.double_quote_mode = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] sep, input logic [7:0] quo,
                             input logic [7:0] esc, input logic dq);
      csr_write(REG_SEPARATOR, {24'($urandom), sep});
      csr_write(REG_QUOTE, {24'($urandom), quo});
      csr_write(REG_ESCAPE, {24'($urandom), esc});
      csr_write(REG_DQ_MODE, {31'($urandom), dq});
   endtask

   // special bytes often, so that quoting and escaping show up
   function automatic logic [7:0] pick_char();
      case ($urandom_range(9))
         0: return cfg_now.separator_char;
         1: return cfg_now.quote_byte;
         2: return cfg_now.escape_byte;
         3: return CH_CR;
         4: return CH_LF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_row();
      int nf;
      int len;
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
         len = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(14, 20);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 4) send_beat(OP_NONE, 8'($urandom));
            send_beat(OP_CHAR, pick_char());
         end
         if (f < nf - 1 || $urandom_range(3) == 0) send_beat(OP_FIELD, 8'($urandom));
         if ($urandom_range(99) < 5) send_beat(OP_FIELD, 8'($urandom));
      end
      send_beat(OP_ROW, 8'($urandom));
   endtask

   task automatic test_plain_fields();
      send_beat(OP_CHAR, 8'h61);
      send_beat(OP_CHAR, 8'h00);
      send_beat(OP_CHAR, 8'hff);
      send_beat(OP_FIELD, 8'h00);
      send_beat(OP_FIELD, 8'hff);
      send_beat(OP_NONE, 8'h5a);
      send_beat(OP_ROW, 8'h00);
   endtask

   task automatic test_quoting();
      send_beat(OP_CHAR, 8'h78);
      send_beat(OP_CHAR, cfg_now.separator_char);
      send_beat(OP_CHAR, cfg_now.quote_byte);
      send_beat(OP_CHAR, cfg_now.escape_byte);
      send_beat(OP_CHAR, CH_CR);
      send_beat(OP_CHAR, CH_LF);
      send_beat(OP_ROW, 8'h00);
   endtask

   // dropped quote must not turn the field into a quoted one
   task automatic test_overflow();
      for (int i = 0; i < FIELD_MAX; i++) send_beat(OP_CHAR, 8'h41 + 8'(i));
      send_beat(OP_CHAR, cfg_now.quote_byte);
      send_beat(OP_ROW, 8'h00);
   endtask

   task automatic test_registers();
      drain();
      set_config(8'h00, 8'hff, 8'h00, 1'b0);
      repeat (2) send_row();
      drain();
      set_config(8'hff, 8'h00, 8'h00, 1'b1);
      repeat (2) send_row();
      drain();
      set_config(8'h09, 8'h09, 8'hff, 1'b0);
      repeat (2) send_row();
      drain();
      set_config(8'hff, 8'hff, 8'hff, 1'b1);
      repeat (2) send_row();
   endtask

   task automatic test_backpressure();
      drain();
      set_config(RESET_SEPARATOR, RESET_QUOTE, RESET_ESCAPE, 1'b1);
      hold_left <= 300;
      send_beat(OP_CHAR, 8'h61);
      send_beat(OP_FIELD, 8'h00);
      for (int i = 0; i < FIELD_MAX; i++) send_beat(OP_CHAR, cfg_now.quote_byte);
      send_beat(OP_ROW, 8'h00);
      send_row();
      drain();
   endtask

   task automatic test_random();
      int base;
      logic [7:0] sep;
      logic [7:0] quo;
      logic [7:0] esc;
      base = sent;
      for (int chunk = 0; chunk < 4; chunk++) begin
         drain();
         sep = 8'($urandom);
         quo = ($urandom_range(3) == 0) ? sep : 8'($urandom);
         esc = ($urandom_range(3) == 0) ? quo : 8'($urandom);
         set_config(sep, quo, esc, 1'($urandom));
         quiet <= (chunk == 2);
         while (sent < base + (chunk + 1) * 22) send_row();
      end
      quiet <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_plain_fields();
      test_quoting();
      test_overflow();
      test_registers();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("[separated_values_row_encoder_core] OK");
      end else begin
         $display("[separated_values_row_encoder_core] ERROR");
      end
      $finish;
   end

endmodule
